@@ hw/rtl/sitr_pkg.sv @@
// Shared constants for the signed integer to radix text converter.
// Used by the divider and the top level; no dependencies.
package sitr_pkg;

    // default width of the converted value
    localparam int VALUE_WIDTH_DEF = 32;
    // width of the radix register and of the divisor path
    localparam int RADIX_WIDTH     = 32;
    // width of one ASCII character
    localparam int CHAR_WIDTH      = 7;

    // radix after reset
    localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = 32'd16;
    // base for writing large digit values in decimal
    localparam logic [RADIX_WIDTH-1:0] DEC_BASE    = 32'd10;
    // first digit value that no longer has a letter
    localparam logic [RADIX_WIDTH-1:0] LETTER_LIMIT = 32'd36;

    // character codes
    localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_A     = 7'h41;
    localparam logic [CHAR_WIDTH-1:0] CH_LPAR  = 7'h28;
    localparam logic [CHAR_WIDTH-1:0] CH_RPAR  = 7'h29;
    localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_WIDTH-1:0] CH_NONE  = 7'h00;

endpackage

@@ hw/rtl/sitr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module sitr_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 144
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/sitr_div.sv @@
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on sitr_pkg for the divisor width.
module sitr_div #(
    parameter int VALUE_WIDTH = sitr_pkg::VALUE_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [VALUE_WIDTH-1:0]           i_dividend,
    input  logic [sitr_pkg::RADIX_WIDTH-1:0] i_divisor,
    output logic                             o_done,
    output logic [VALUE_WIDTH-1:0]           o_quotient,
    output logic [sitr_pkg::RADIX_WIDTH-1:0] o_remainder
);

    import sitr_pkg::*;

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic                   r_busy;
    logic                   r_done;
    logic [CW-1:0]          r_cnt;
    logic [VALUE_WIDTH-1:0] r_quo;
    logic [RADIX_WIDTH-1:0] r_rem;
    logic [RADIX_WIDTH-1:0] r_dsr;

    logic [RADIX_WIDTH:0]   trial;
    logic [RADIX_WIDTH:0]   diff;
    logic                   fits;

    // trial subtract of the shifted partial remainder
    always_comb begin
        trial = {r_rem, r_quo[VALUE_WIDTH-1]};
        diff  = trial - {1'b0, r_dsr};
        fits  = trial >= {1'b0, r_dsr};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(VALUE_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: shift dividend bits out, quotient bits in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[VALUE_WIDTH-2:0], fits};
            r_rem <= fits ? diff[RADIX_WIDTH-1:0] : trial[RADIX_WIDTH-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

@@ hw/rtl/signed_integer_to_radix_text_top.sv @@
// Signed integer to radix text converter, top level.
// Depends on sitr_pkg, sitr_div and sitr_ram.
// Sequence: each digit takes one division in the shared divider (a start state, then a wait);
//   a digit of 36 or more adds a division per decimal character and a parenthesis state.
//   After the text is built, one character per cycle leaves, read from the registered RAM.
//   busy stays high until the last character is read; it is low as that character leaves.
// Invalid radix: one flagged result the cycle after start. Reset (synchronous, active low)
//   returns the sequencer to idle and the radix to 16; the receiver cannot stall results.
module signed_integer_to_radix_text_top #(
    parameter int VALUE_WIDTH = sitr_pkg::VALUE_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // conversion command
    input  logic                             start,
    output logic                             busy,
    input  logic [VALUE_WIDTH-1:0]           i_value,
    // result strobe and fields
    output logic                             o_strobe,
    output logic [sitr_pkg::CHAR_WIDTH-1:0]  o_character,
    output logic                             o_last,
    output logic                             o_bad_radix,
    // radix register write
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sitr_pkg::RADIX_WIDTH-1:0] i_cfg_radix
);

    import sitr_pkg::*;

    localparam int DEPTH = 4 * VALUE_WIDTH + 16;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(DEPTH + 1);
    localparam int XW    = VALUE_WIDTH + RADIX_WIDTH;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIG_GO,
        S_DIG_WAIT,
        S_DEC_GO,
        S_DEC_WAIT,
        S_PAREN,
        S_SIGN,
        S_EMIT
    } t_state;

    t_state                 r_state, n_state;
    logic [RADIX_WIDTH-1:0] r_radix;
    logic [RADIX_WIDTH-1:0] r_base, n_base;
    logic [VALUE_WIDTH-1:0] r_mag, n_mag;
    logic [RADIX_WIDTH-1:0] r_digit, n_digit;
    logic                   r_neg, n_neg;
    logic [PW-1:0]          r_ptr, n_ptr;
    logic                   r_rv, n_rv;
    logic                   r_rlast, n_rlast;
    logic                   r_bad, n_bad;

    logic                   we;
    logic [CHAR_WIDTH-1:0]  wdata;
    logic [AW-1:0]          raddr;
    logic [CHAR_WIDTH-1:0]  rdata;

    logic                   div_start;
    logic [VALUE_WIDTH-1:0] div_dividend;
    logic [RADIX_WIDTH-1:0] div_divisor;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_quo;
    logic [RADIX_WIDTH-1:0] div_rem;

    logic [XW-1:0]          digit_ext;
    logic [XW-1:0]          quo_ext;
    logic [CHAR_WIDTH-1:0]  digit_char;
    logic                   radix_bad;
    logic [PW-1:0]          rd_ptr;

    sitr_div #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    sitr_ram #(
        .WIDTH(CHAR_WIDTH),
        .DEPTH(DEPTH)
    ) u_text (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_ptr[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // radix register: always ready; it is to be written only while idle, which the block does not enforce
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_radix <= i_cfg_radix;
        end
    end

    // operand selection for the shared divider
    always_comb begin
        digit_ext    = XW'(r_digit);
        quo_ext      = XW'(div_quo);
        div_start    = (r_state == S_DIG_GO) || (r_state == S_DEC_GO);
        div_dividend = (r_state == S_DIG_GO) ? r_mag : digit_ext[VALUE_WIDTH-1:0];
        div_divisor  = (r_state == S_DIG_GO) ? r_base : DEC_BASE;
    end

    // map a digit value below 36 to its character
    always_comb begin
        if (div_rem < DEC_BASE) begin
            digit_char = CH_ZERO + CHAR_WIDTH'(div_rem[3:0]);
        end else begin
            digit_char = CH_A + CHAR_WIDTH'(div_rem[5:0]) - CHAR_WIDTH'(DEC_BASE);
        end
    end

    assign radix_bad = (r_radix == '0) || (r_radix == RADIX_WIDTH'(1)) || (r_radix == '1);
    assign rd_ptr    = r_ptr - 1'b1;
    assign raddr     = rd_ptr[AW-1:0];

    // sequencer next state
    always_comb begin
        n_state = r_state;
        n_base  = r_base;
        n_mag   = r_mag;
        n_digit = r_digit;
        n_neg   = r_neg;
        n_ptr   = r_ptr;
        n_rv    = 1'b0;
        n_rlast = 1'b0;
        n_bad   = 1'b0;
        we      = 1'b0;
        wdata   = CH_NONE;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_neg  = i_value[VALUE_WIDTH-1];
                    n_mag  = i_value[VALUE_WIDTH-1] ? (~i_value + 1'b1) : i_value;
                    n_base = r_radix[RADIX_WIDTH-1] ? (~r_radix + 1'b1) : r_radix;
                    n_ptr  = '0;
                    if (radix_bad) begin
                        n_bad = 1'b1;
                    end else begin
                        n_state = S_DIG_GO;
                    end
                end
            end
            S_DIG_GO: begin
                n_state = S_DIG_WAIT;
            end
            S_DIG_WAIT: begin
                if (div_done) begin
                    n_mag = div_quo;
                    we    = 1'b1;
                    n_ptr = r_ptr + 1'b1;
                    if (div_rem < LETTER_LIMIT) begin
                        wdata   = digit_char;
                        n_state = (div_quo != '0) ? S_DIG_GO : S_SIGN;
                    end else begin
                        wdata   = CH_RPAR;
                        n_digit = div_rem;
                        n_state = S_DEC_GO;
                    end
                end
            end
            S_DEC_GO: begin
                n_state = S_DEC_WAIT;
            end
            S_DEC_WAIT: begin
                if (div_done) begin
                    we      = 1'b1;
                    wdata   = CH_ZERO + CHAR_WIDTH'(div_rem[3:0]);
                    n_ptr   = r_ptr + 1'b1;
                    n_digit = quo_ext[RADIX_WIDTH-1:0];
                    n_state = (div_quo == '0) ? S_PAREN : S_DEC_GO;
                end
            end
            S_PAREN: begin
                we      = 1'b1;
                wdata   = CH_LPAR;
                n_ptr   = r_ptr + 1'b1;
                n_state = (r_mag != '0) ? S_DIG_GO : S_SIGN;
            end
            S_SIGN: begin
                if (r_neg) begin
                    we    = 1'b1;
                    wdata = CH_MINUS;
                    n_ptr = r_ptr + 1'b1;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                // read back most significant first; data arrives next cycle
                n_ptr   = rd_ptr;
                n_rv    = 1'b1;
                n_rlast = (r_ptr == PW'(1));
                if (r_ptr == PW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered controls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ptr   <= '0;
            r_rv    <= 1'b0;
            r_rlast <= 1'b0;
            r_bad   <= 1'b0;
            r_neg   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_rv    <= n_rv;
            r_rlast <= n_rlast;
            r_bad   <= n_bad;
            r_neg   <= n_neg;
        end
        r_base  <= n_base;
        r_mag   <= n_mag;
        r_digit <= n_digit;
    end

    // result transfer
    assign busy        = (r_state != S_IDLE);
    assign o_strobe    = r_rv || r_bad;
    assign o_character = r_bad ? CH_NONE : rdata;
    assign o_last      = r_rlast || r_bad;
    assign o_bad_radix = r_bad;

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for signed_integer_to_radix_text_top.
// Depends on sitr_pkg and the converter RTL; drives a directed table, then random radix phases.
`timescale 1ns / 100ps

module tb_top;

    import sitr_pkg::*;

    localparam int VW            = 32;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 286;
    localparam int QUIET_ITEMS   = 40;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int DIRECTED_ROWS = 24;
    localparam int SWEEP_PHASES  = 8;

    // how a directed row gets its expected text
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_TEXT,
        CHK_BAD
    } t_row_check;

    typedef struct packed {
        logic [RADIX_WIDTH-1:0] radix;
        logic [VW-1:0]          value;
        t_row_check             check;
    } t_dir_row;

    // one expected character of the emitted text
    typedef struct packed {
        logic [CHAR_WIDTH-1:0] ch;
        logic                  last;
        logic                  bad;
    } t_text_char;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   start       = 1'b0;
    logic                   busy;
    logic [VW-1:0]          i_value     = '0;
    logic                   o_strobe;
    logic [CHAR_WIDTH-1:0]  o_character;
    logic                   o_last;
    logic                   o_bad_radix;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [RADIX_WIDTH-1:0] i_cfg_radix = '0;

    t_text_char             pending_text [$];
    logic [RADIX_WIDTH-1:0] cur_radix    = RADIX_RESET;
    int                     errors       = 0;
    int                     values_sent  = 0;
    int                     chars_seen   = 0;
    int                     radix_writes = 0;

    // directed stimulus: radix to use, value, and where the expectation comes from
    t_dir_row dir_table [DIRECTED_ROWS] = '{
        '{32'd16,         32'd0,          CHK_TEXT},
        '{32'd16,         32'h7FFF_FFFF,  CHK_TEXT},
        '{32'd16,         32'h8000_0000,  CHK_TEXT},
        '{32'd16,         32'hFFFF_FFFF,  CHK_TEXT},
        '{32'd16,         32'h1234_5678,  CHK_TEXT},
        '{32'd2,          32'd5,          CHK_TEXT},
        '{32'd2,          32'h8000_0000,  CHK_MODEL},
        '{32'd2,          32'h7FFF_FFFF,  CHK_MODEL},
        '{32'd10,         32'hFFFF_CFC7,  CHK_TEXT},
        '{32'd10,         32'h8000_0000,  CHK_TEXT},
        '{32'd36,         32'd35,         CHK_TEXT},
        '{32'd36,         32'd36,         CHK_TEXT},
        '{32'd37,         32'd36,         CHK_TEXT},
        '{32'd37,         32'hFFFF_FFDB,  CHK_TEXT},
        '{32'd100,        32'd123456,     CHK_MODEL},
        '{32'hFFFF_FFF0,  32'd255,        CHK_TEXT},
        '{32'h8000_0000,  32'h7FFF_FFFF,  CHK_TEXT},
        '{32'h8000_0000,  32'h8000_0000,  CHK_TEXT},
        '{32'h7FFF_FFFF,  32'h7FFF_FFFF,  CHK_TEXT},
        '{32'h7FFF_FFFF,  32'h8000_0000,  CHK_TEXT},
        '{32'd0,          32'd5,          CHK_BAD},
        '{32'd1,          32'd0,          CHK_BAD},
        '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  CHK_BAD},
        '{32'd3,          32'hDEAD_BEEF,  CHK_MODEL}
    };

    string dir_text [DIRECTED_ROWS] = '{
        "0", "7FFFFFFF", "-80000000", "-1", "12345678", "101", "", "",
        "-12345", "-2147483648", "Z", "10", "(36)", "-10", "", "FF",
        "(2147483647)", "-10", "10", "-11", "", "", "", ""
    };

    // fixed radix sweep ahead of the random phases
    logic [RADIX_WIDTH-1:0] sweep_radix [SWEEP_PHASES] = '{
        32'd10, 32'd2, 32'd36, 32'd37, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'd0
    };

    signed_integer_to_radix_text_top #(
        .VALUE_WIDTH (VW)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .o_strobe    (o_strobe),
        .o_character (o_character),
        .o_last      (o_last),
        .o_bad_radix (o_bad_radix),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_radix (i_cfg_radix)
    );

    // 4 ns clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // radix -1, 0 and 1 have no usable magnitude
    function automatic logic is_bad_radix(input logic [RADIX_WIDTH-1:0] r);
        return (r == 32'd0) || (r == 32'd1) || (r == 32'hFFFF_FFFF);
    endfunction

    // append the text of one value in the current radix
    function automatic void predict_text(input logic [VW-1:0] value);
        logic [CHAR_WIDTH-1:0] rev [$];
        logic [VW:0]           mag;
        logic [VW:0]           base;
        logic [VW:0]           digit;
        logic [VW:0]           dec_digit;
        logic [CHAR_WIDTH-1:0] low7;
        t_text_char            tc;
        if (is_bad_radix(cur_radix)) begin
            tc = '{ch: CH_NONE, last: 1'b1, bad: 1'b1};
            pending_text.push_back(tc);
            return;
        end
        mag  = {1'b0, value[VW-1] ? (~value + 1'b1) : value};
        base = {1'b0, cur_radix[RADIX_WIDTH-1] ? (~cur_radix + 1'b1) : cur_radix};
        // collect least significant first
        do begin
            digit = mag % base;
            mag   = mag / base;
            if (digit < DEC_BASE) begin
                low7 = digit[CHAR_WIDTH-1:0];
                rev.push_back(CH_ZERO + low7);
            end else if (digit < LETTER_LIMIT) begin
                low7 = digit[CHAR_WIDTH-1:0] - DEC_BASE[CHAR_WIDTH-1:0];
                rev.push_back(CH_A + low7);
            end else begin
                // large digit: decimal inside parentheses
                rev.push_back(CH_RPAR);
                do begin
                    dec_digit = digit % DEC_BASE;
                    low7      = dec_digit[CHAR_WIDTH-1:0];
                    rev.push_back(CH_ZERO + low7);
                    digit = digit / DEC_BASE;
                end while (digit != 0);
                rev.push_back(CH_LPAR);
            end
        end while (mag != 0);
        if (value[VW-1])
            rev.push_back(CH_MINUS);
        for (int i = rev.size() - 1; i >= 0; i--) begin
            tc = '{ch: rev[i], last: (i == 0), bad: 1'b0};
            pending_text.push_back(tc);
        end
    endfunction

    function automatic logic [VW-1:0] pick_value();
        logic [VW-1:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0:       v = 32'd0;
                    1:       v = 32'd1;
                    2:       v = 32'hFFFF_FFFF;
                    3:       v = 32'h7FFF_FFFF;
                    default: v = 32'h8000_0000;
                endcase
            end
            1, 2: v = $urandom_range(0, 100);
            3:    v = 32'd1 << $urandom_range(0, 31);
            default: v = $urandom();
        endcase
        // flip sign now and then
        if ($urandom_range(0, 2) == 0)
            v = ~v + 1'b1;
        return v;
    endfunction

    function automatic logic [RADIX_WIDTH-1:0] pick_radix();
        logic [RADIX_WIDTH-1:0] r;
        case ($urandom_range(0, 7))
            0: r = $urandom_range(2, 16);
            1: r = $urandom_range(17, 36);
            2: r = $urandom_range(37, 200);
            3: r = $urandom();
            4: r = ~RADIX_WIDTH'($urandom_range(2, 64)) + 1'b1;
            5: begin
                case ($urandom_range(0, 2))
                    0:       r = 32'd0;
                    1:       r = 32'd1;
                    default: r = 32'hFFFF_FFFF;
                endcase
            end
            default: r = $urandom_range(2, 40);
        endcase
        return r;
    endfunction

    // hold start high with the value and wait until the block is no longer busy
    task automatic transfer_value(input logic [VW-1:0] value, input t_row_check check,
                                  input string text);
        byte        b;
        t_text_char tc;
        @(negedge i_clk);
        start   <= 1'b1;
        i_value <= value;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        values_sent++;
        case (check)
            CHK_TEXT: begin
                for (int i = 0; i < text.len(); i++) begin
                    b  = text[i];
                    tc = '{ch: b[CHAR_WIDTH-1:0], last: (i == text.len() - 1), bad: 1'b0};
                    pending_text.push_back(tc);
                end
            end
            CHK_BAD: begin
                tc = '{ch: CH_NONE, last: 1'b1, bad: 1'b1};
                pending_text.push_back(tc);
            end
            default: predict_text(value);
        endcase
    endtask

    // drop start with noise on the value bus
    task automatic idle_sender(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start   <= 1'b0;
            i_value <= $urandom();
        end
    endtask

    // drop start and hold off until all text is out and the block has settled
    task automatic wait_text_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_text.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES)
            @(posedge i_clk);
    endtask

    task automatic write_radix(input logic [RADIX_WIDTH-1:0] r);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_radix <= r;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        cur_radix = r;
        radix_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        i_cfg_radix <= $urandom();
    endtask

    // compare each strobed character with the oldest expectation
    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n && o_strobe) begin
            chars_seen++;
            if (pending_text.size() == 0) begin
                $error("unexpected character %h (last %b, bad_radix %b)",
                       o_character, o_last, o_bad_radix);
                errors++;
            end else begin
                want = pending_text.pop_front();
                if (o_character !== want.ch) begin
                    $error("character: expected %h, got %h", want.ch, o_character);
                    errors++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, o_last);
                    errors++;
                end
                if (o_bad_radix !== want.bad) begin
                    $error("bad_radix: expected %b, got %b", want.bad, o_bad_radix);
                    errors++;
                end
            end
        end
    end

    // end a hung run
    initial begin : watchdog
        repeat (CYCLE_LIMIT)
            @(posedge i_clk);
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin : stimulus
        logic [RADIX_WIDTH-1:0] r;
        int                     phase;
        int                     count;
        int                     random_sent;
        logic                   paused;
        phase       = 0;
        random_sent = 0;
        paused      = 1'b0;
        repeat (RESET_CYCLES)
            @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table; the first rows run on the reset radix
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (dir_table[i].radix != cur_radix) begin
                wait_text_drained();
                write_radix(dir_table[i].radix);
            end
            transfer_value(dir_table[i].value, dir_table[i].check, dir_text[i]);
        end

        // random phases, one radix each
        while (random_sent < RANDOM_ITEMS) begin
            r = (phase < SWEEP_PHASES) ? sweep_radix[phase] : pick_radix();
            phase++;
            wait_text_drained();
            write_radix(r);
            count = is_bad_radix(r) ? 4 : $urandom_range(12, 28);
            for (int k = 0; k < count && random_sent < RANDOM_ITEMS; k++) begin
                if (random_sent < RANDOM_ITEMS - QUIET_ITEMS && $urandom_range(0, 2) == 0)
                    idle_sender($urandom_range(1, 11));
                // once mid-run, hold off until the text is fully out
                if (!paused && random_sent >= RANDOM_ITEMS / 2) begin
                    wait_text_drained();
                    paused = 1'b1;
                end
                transfer_value(pick_value(), CHK_MODEL, "");
                random_sent++;
            end
        end

        wait_text_drained();
        $display("tb_top: %0d values converted over %0d radix writes, %0d characters checked",
                 values_sent, radix_writes, chars_seen);
        $display("tb_top: covered extremes, invalid radices, negative and huge bases");
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
